/* sv/mkbs_pkg.sv */
// Shared types and constants for the masked-key binary search block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package mkbs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int CFG_W       = 11;
	localparam int CLAMP_W     = (CFG_W > CNT_W) ? CFG_W : CNT_W;
	localparam int WORD_W      = 64;
	localparam int CLASS_W     = 4;
	localparam int KEY_W       = WORD_W - CLASS_W;
	localparam int IN_INDEX_W  = 10;
	localparam int S_DATA_W    = 144;
	localparam int M_DATA_W    = 8;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_HOLD
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic step;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic lookup;
		logic empty;
		logic stop;
	} dp_stat_t;

endpackage

/* sv/masked_key_binary_search.sv */
// Top level of the masked-key binary search block.
// Depends on mkbs_pkg, mkbs_ctrl and mkbs_dp.
`timescale 1ns / 1ps

// A write word (tuser 0) stores one table word. A lookup word (tuser 1)
// binary-searches the first entry_count table words, clamped to the table
// depth, with at most log2(depth) + 1 probes, so 11 or fewer for 1024
// entries; each probe is one registered read of the single-port table memory
// followed by the key compare. A lookup on an empty table answers with the
// error flag set and no probe. One word is worked on at a time; the result
// register lets the next word be accepted while the previous result waits.
// The table has no reset: only searches that touch written entries give
// defined results. entry_count may be written only while the block is idle.
module masked_key_binary_search (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [mkbs_pkg::CFG_W-1:0]     cfg_wdata,     // entry_count
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mkbs_pkg::S_DATA_W-1:0]  s_tdata,       // entry_index, entry_word, key_hash
	input  logic [0:0]                     s_tuser,       // func
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mkbs_pkg::M_DATA_W-1:0]  m_tdata        // class_id, found, error
);

	mkbs_pkg::dp_cmd_t  cmd;
	mkbs_pkg::dp_stat_t stat;

	mkbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mkbs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.func        (s_tuser[0]),
		.entry_index (s_tdata[9:0]),
		.entry_word  (s_tdata[73:10]),
		.key_hash    (s_tdata[137:74]),
		.cmd         (cmd),
		.stat        (stat),
		.m_tdata     (m_tdata)
	);

endmodule

/* sv/mkbs_ctrl.sv */
// Controller state machine for the masked-key binary search block.
// Depends on mkbs_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps

module mkbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  mkbs_pkg::dp_stat_t stat,
	output mkbs_pkg::dp_cmd_t  cmd
);

	mkbs_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mkbs_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (stat.lookup && !stat.empty) state_d = mkbs_pkg::ST_PROBE;
					else state_d = mkbs_pkg::ST_HOLD;
				end
			end
			mkbs_pkg::ST_PROBE: begin
				if (stat.stop) state_d = mkbs_pkg::ST_HOLD;
			end
			mkbs_pkg::ST_HOLD: begin
				if (out_free) state_d = mkbs_pkg::ST_IDLE;
			end
			default: state_d = mkbs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.start    = 1'b0;
		cmd.step     = 1'b0;
		cmd.out_load = 1'b0;
		unique case (state_q)
			mkbs_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				cmd.start = s_tvalid;
			end
			mkbs_pkg::ST_PROBE: begin
				cmd.step = 1'b1;
			end
			mkbs_pkg::ST_HOLD: begin
				cmd.out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mkbs_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

/* sv/mkbs_dp.sv */
// Datapath for the masked-key binary search: table memory, search bounds,
// key compare and result registers. Depends on mkbs_pkg.
`timescale 1ns / 1ps

module mkbs_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [mkbs_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         func,
	input  logic [mkbs_pkg::IN_INDEX_W-1:0] entry_index,
	input  logic [mkbs_pkg::WORD_W-1:0]  entry_word,
	input  logic [mkbs_pkg::WORD_W-1:0]  key_hash,
	input  mkbs_pkg::dp_cmd_t            cmd,
	output mkbs_pkg::dp_stat_t           stat,
	output logic [mkbs_pkg::M_DATA_W-1:0] m_tdata
);

	logic [mkbs_pkg::WORD_W-1:0]  mem [mkbs_pkg::TABLE_DEPTH];
	logic [mkbs_pkg::WORD_W-1:0]  rdata_q;
	logic [mkbs_pkg::CFG_W-1:0]   count_q;
	logic [mkbs_pkg::CNT_W-1:0]   lb_q, ub_q;
	logic [mkbs_pkg::IDX_W-1:0]   mid_q;
	logic [mkbs_pkg::KEY_W-1:0]   target_q;
	logic [mkbs_pkg::CLASS_W-1:0] res_id_q;
	logic                         res_found_q;
	logic                         res_err_q;
	logic [mkbs_pkg::M_DATA_W-1:0] out_q;

	logic [mkbs_pkg::CLAMP_W-1:0] count_ext;
	logic [mkbs_pkg::CNT_W-1:0]   n_eff;
	logic                         wr_ok;
	logic [mkbs_pkg::KEY_W-1:0]   probe;
	logic                         eq, gt;
	logic [mkbs_pkg::CNT_W-1:0]   lb_d, ub_d;
	logic [mkbs_pkg::CNT_W:0]     sum_d;
	logic [mkbs_pkg::IDX_W-1:0]   mid_d;
	logic                         rd_en;
	logic [mkbs_pkg::IDX_W-1:0]   rd_addr;

	// A count beyond the table is searched as the whole table.
	assign count_ext = mkbs_pkg::CLAMP_W'(count_q);
	assign n_eff = (count_ext > mkbs_pkg::CLAMP_W'(mkbs_pkg::TABLE_DEPTH)) ?
		mkbs_pkg::CNT_W'(mkbs_pkg::TABLE_DEPTH) : mkbs_pkg::CNT_W'(count_ext);

	assign wr_ok = (32'(entry_index) < 32'(mkbs_pkg::TABLE_DEPTH));

	assign probe = rdata_q[mkbs_pkg::WORD_W-1:mkbs_pkg::CLASS_W];
	assign eq    = (probe == target_q);
	assign gt    = (probe > target_q);

	always_comb begin
		lb_d  = gt ? lb_q : mkbs_pkg::CNT_W'(mid_q);
		ub_d  = gt ? mkbs_pkg::CNT_W'(mid_q) : ub_q;
		sum_d = (mkbs_pkg::CNT_W + 1)'(lb_d) + (mkbs_pkg::CNT_W + 1)'(ub_d);
		mid_d = mkbs_pkg::IDX_W'(sum_d[mkbs_pkg::CNT_W:1]);
	end

	assign stat.lookup = (func == mkbs_pkg::FUNC_LOOKUP);
	assign stat.empty  = (n_eff == '0);
	assign stat.stop   = eq || (mid_d == mid_q);

	// The first probe address is issued with the accepted word; each probe
	// cycle that does not end the search issues the next one.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mid_d;
		if (cmd.start) begin
			rd_en   = stat.lookup && !stat.empty;
			rd_addr = mkbs_pkg::IDX_W'(n_eff >> 1);
		end else if (cmd.step) begin
			rd_en = !stat.stop;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && !stat.lookup && wr_ok)
			mem[mkbs_pkg::IDX_W'(entry_index)] <= entry_word;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_wen) begin
			count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lb_q        <= '0;
			ub_q        <= n_eff;
			mid_q       <= mkbs_pkg::IDX_W'(n_eff >> 1);
			target_q    <= key_hash[mkbs_pkg::WORD_W-1:mkbs_pkg::CLASS_W];
			res_id_q    <= '0;
			res_found_q <= 1'b0;
			res_err_q   <= stat.lookup && stat.empty;
		end else if (cmd.step) begin
			if (stat.stop) begin
				res_id_q    <= eq ? rdata_q[mkbs_pkg::CLASS_W-1:0] : '0;
				res_found_q <= eq;
				res_err_q   <= eq && (rdata_q[mkbs_pkg::CLASS_W-1:0] == '0);
			end else begin
				lb_q  <= lb_d;
				ub_q  <= ub_d;
				mid_q <= mid_d;
			end
		end
		if (cmd.out_load) out_q <= {2'b00, res_err_q, res_found_q, res_id_q};
	end

	assign m_tdata = out_q;

endmodule

/* sv/mkbs_checker.sv */
// Port-level checker for masked_key_binary_search, attached with bind.
// Depends on mkbs_pkg for port widths.
`timescale 1ns / 1ps

module mkbs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [mkbs_pkg::M_DATA_W-1:0] m_tdata
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// Without a match the class id is zero.
	a_miss_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[4] |-> m_tdata[3:0] == 4'd0)
		else $error("class id set without a match");

	// A match flagged as an error carries class id zero.
	a_err_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] && m_tdata[5] |-> m_tdata[3:0] == 4'd0)
		else $error("error on a match with a nonzero class id");

	// Words are taken one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a word is in progress");

endmodule

bind masked_key_binary_search mkbs_checker u_mkbs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* sim/tb_masked_key_binary_search.sv */
// Self-checking testbench for masked_key_binary_search: table writes and masked-key lookups
// on a stream interface, with its own table copy to predict every result word.
// Depends on mkbs_pkg and masked_key_binary_search.
`timescale 1ns / 1ps

module tb_masked_key_binary_search;
	import mkbs_pkg::*;

	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic                  drain;        // hold this word back until no result is outstanding
		logic                  func;
		logic [IN_INDEX_W-1:0] entry_index;
		logic [WORD_W-1:0]     entry_word;
		logic [WORD_W-1:0]     key_hash;
	} table_op_t;

	typedef struct packed {
		logic               error;
		logic               found;
		logic [CLASS_W-1:0] class_id;
	} verdict_t;

	typedef enum {KEEP_TABLE, SORTED_FILL, SHUFFLED_FILL} refill_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_wen = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [0:0]          s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	// Words waiting to be sent and result words waiting to arrive.
	table_op_t   pending_ops[$];
	verdict_t    verdicts_due[$];
	table_op_t   on_bus;
	bit          on_bus_busy = 1'b0;
	bit          calm = 1'b0;

	// Predictor state and the stimulus side's own record of what it wrote.
	logic [WORD_W-1:0] model_table [TABLE_DEPTH];
	logic [CFG_W-1:0]  model_count = '0;
	logic [WORD_W-1:0] plan_table [TABLE_DEPTH];

	int unsigned quiet_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned n_writes = 0, n_lookups = 0, n_hits = 0, n_zero_id = 0;
	int unsigned n_absent = 0, n_empty = 0;

	masked_key_binary_search DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Probe rule: midpoint of [lo, hi), stop on a match or once the midpoint stays put.
	function automatic verdict_t search_table(logic [WORD_W-1:0] hash);
		verdict_t          v;
		int unsigned       span, lo, hi, mid;
		logic [KEY_W-1:0]  target, probe;
		v = '0;
		span = (model_count > TABLE_DEPTH) ? TABLE_DEPTH : model_count;
		if (span == 0) begin
			v.error = 1'b1;
			return v;
		end
		target = hash[WORD_W-1:CLASS_W];
		lo = 0;
		hi = span;
		for (int g = 0; g < 64; g++) begin
			mid = (lo + hi) / 2;
			probe = model_table[mid][WORD_W-1:CLASS_W];
			if (probe == target) begin
				v.found = 1'b1;
				v.class_id = model_table[mid][CLASS_W-1:0];
				v.error = (v.class_id == 0);
				return v;
			end else if (probe > target) begin
				hi = mid;
			end else begin
				lo = mid;
			end
			if (mid == (lo + hi) / 2)
				break;
		end
		return v;
	endfunction

	function automatic void apply_word(table_op_t w);
		verdict_t v;
		v = '0;
		if (w.func == FUNC_WRITE) begin
			model_table[w.entry_index] = w.entry_word;
			n_writes++;
		end else begin
			v = search_table(w.key_hash);
			n_lookups++;
			if (model_count == 0)
				n_empty++;
			else if (!v.found)
				n_absent++;
			else if (v.error)
				n_zero_id++;
			else
				n_hits++;
		end
		verdicts_due.push_back(v);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d, expected %0d (result word %0d)",
			what, got, want, results_checked);
		mismatches++;
	endtask

	// Driver: one word on the bus at a time, random idle cycles between words unless calm is set.
	always @(posedge clk) begin : drive_proc
		logic busy;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				apply_word(on_bus);
				on_bus_busy = 1'b0;
				busy = 1'b0;
			end
			if (!busy) begin
				if (pending_ops.size() != 0 &&
					!(pending_ops[0].drain && verdicts_due.size() != 0) &&
					(calm || $urandom_range(99) >= 26)) begin
					on_bus = pending_ops.pop_front();
					on_bus_busy = 1'b1;
					s_tdata <= {6'b0, on_bus.key_hash, on_bus.entry_word, on_bus.entry_index};
					s_tuser <= on_bus.func;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result word with the oldest prediction.
	always @(posedge clk) begin : check_proc
		verdict_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdicts_due.size() == 0) begin
					report_mismatch("result word with none outstanding", m_tdata, 0);
				end else begin
					want = verdicts_due.pop_front();
					if (m_tdata[3:0] !== want.class_id)
						report_mismatch("class_id", m_tdata[3:0], want.class_id);
					if (m_tdata[4] !== want.found)
						report_mismatch("found", m_tdata[4], want.found);
					if (m_tdata[5] !== want.error)
						report_mismatch("error", m_tdata[5], want.error);
				end
				results_checked++;
			end
			m_tready <= calm || ($urandom_range(99) >= 26);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= STALL_LIMIT);
		$display("No word accepted for %0d cycles", STALL_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic queue_write(int unsigned idx, logic [WORD_W-1:0] word);
		table_op_t w;
		w.drain = 1'b0;
		w.func = FUNC_WRITE;
		w.entry_index = IN_INDEX_W'(idx);
		w.entry_word = word;
		w.key_hash = rand64();
		plan_table[idx] = word;
		pending_ops.push_back(w);
	endtask

	task automatic queue_lookup(logic [WORD_W-1:0] hash, bit drain);
		table_op_t w;
		w.drain = drain;
		w.func = FUNC_LOOKUP;
		w.entry_index = IN_INDEX_W'($urandom);
		w.entry_word = rand64();
		w.key_hash = hash;
		pending_ops.push_back(w);
	endtask

	// Mostly keys present in the table, some just beside a stored key, some anywhere.
	task automatic queue_random_lookup(int unsigned span, bit drain);
		logic [WORD_W-1:0] h;
		int unsigned       pick, roll;
		h = rand64();
		roll = $urandom_range(9);
		if (span != 0 && roll < 6) begin
			pick = $urandom_range(span - 1);
			h = {plan_table[pick][WORD_W-1:CLASS_W], h[CLASS_W-1:0]};
		end else if (span != 0 && roll == 6) begin
			pick = $urandom_range(span - 1);
			if ($urandom_range(1))
				h = plan_table[pick] + 64'h10;
			else
				h = plan_table[pick] - 64'h10;
		end
		queue_lookup(h, drain);
	endtask

	// Strictly ascending keys spread over the whole key range, random class ids.
	task automatic fill_sorted(int unsigned span);
		logic [KEY_W-1:0] stride, key, jitter;
		stride = {KEY_W{1'b1}} / span;
		for (int i = 0; i < span; i++) begin
			jitter = KEY_W'(rand64());
			key = stride * i + jitter % stride;
			queue_write(i, {key, 4'($urandom)});
		end
	endtask

	task automatic settle();
		while (pending_ops.size() != 0 || on_bus_busy || verdicts_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_entry_count(int unsigned count);
		settle();
		cfg_wen <= 1'b1;
		cfg_wdata <= CFG_W'(count);
		@(posedge clk);
		cfg_wen <= 1'b0;
		model_count = CFG_W'(count);
	endtask

	task automatic run_phase(int unsigned count, int unsigned steps, refill_t fill);
		int unsigned       span, hold_at, pick;
		logic [WORD_W-1:0] w;
		span = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
		hold_at = $urandom_range(steps - 1);
		if (fill == SORTED_FILL) begin
			fill_sorted(span);
		end else if (fill == SHUFFLED_FILL) begin
			for (int i = 0; i < span; i++)
				queue_write(i, rand64());
		end
		set_entry_count(count);
		for (int s = 0; s < steps; s++) begin
			if (s != hold_at && span != 0 && $urandom_range(99) < 15) begin
				if (span < TABLE_DEPTH && $urandom_range(1)) begin
					queue_write($urandom_range(TABLE_DEPTH - 1, span), rand64());
				end else begin
					// Same key, new class id, so the table stays sorted.
					pick = $urandom_range(span - 1);
					w = plan_table[pick];
					w[CLASS_W-1:0] = 4'($urandom);
					queue_write(pick, w);
				end
			end else begin
				queue_random_lookup(span, s == hold_at);
			end
		end
	endtask

	// A full-depth search only visits the entries on the way down to the lowest
	// or up to the highest index when its key is the all-zero key, the all-ones
	// key or the key of one of those entries, so only those entries are written.
	task automatic run_edge_phase(int unsigned count, int unsigned steps, bit refill);
		int unsigned       path[$];
		int unsigned       lo, hi, mid, hold_at, pick;
		logic [KEY_W-1:0]  stride;
		logic [WORD_W-1:0] w, h;
		stride = {KEY_W{1'b1}} / TABLE_DEPTH;
		lo = 0;
		hi = TABLE_DEPTH;
		for (int g = 0; g < 64; g++) begin
			mid = (lo + hi) / 2;
			path.push_back(mid);
			hi = mid;
			if (mid == (lo + hi) / 2)
				break;
		end
		hi = TABLE_DEPTH;
		for (int g = 0; g < 64; g++) begin
			mid = (lo + hi) / 2;
			if (mid != TABLE_DEPTH / 2)
				path.push_back(mid);
			lo = mid;
			if (mid == (lo + hi) / 2)
				break;
		end
		if (refill) begin
			foreach (path[i])
				queue_write(path[i], {KEY_W'(stride * path[i] + 1), 4'($urandom)});
		end
		set_entry_count(count);
		hold_at = $urandom_range(steps - 1);
		for (int s = 0; s < steps; s++) begin
			pick = path[$urandom_range(path.size() - 1)];
			if (s != hold_at && $urandom_range(99) < 15) begin
				w = plan_table[pick];
				w[CLASS_W-1:0] = 4'($urandom);
				queue_write(pick, w);
			end else begin
				h = rand64();
				case ($urandom_range(9))
					0: h = {{KEY_W{1'b0}}, h[CLASS_W-1:0]};
					1: h = {{KEY_W{1'b1}}, h[CLASS_W-1:0]};
					default: h = {plan_table[pick][WORD_W-1:CLASS_W], h[CLASS_W-1:0]};
				endcase
				queue_lookup(h, s == hold_at);
			end
		end
	endtask

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Count is zero after reset, so lookups must report an empty table.
		queue_lookup({WORD_W{1'b1}}, 1'b0);
		queue_lookup('0, 1'b0);
		queue_write(0, '0);
		for (int k = 1; k < 7; k++)
			queue_write(k, {4'(k), 56'h0, 4'(k)});
		queue_write(7, {WORD_W{1'b1}});
		queue_write(TABLE_DEPTH - 1, rand64());

		set_entry_count(8);
		queue_lookup('0, 1'b1);
		queue_lookup(64'hF, 1'b0);
		queue_lookup({WORD_W{1'b1}}, 1'b0);
		queue_lookup({4'd3, 56'h0, 4'hA}, 1'b0);
		queue_lookup({4'd3, 56'h1, 4'h0}, 1'b0);
		queue_lookup({4'd5, 56'h0, 4'h5}, 1'b0);

		set_entry_count(1);
		queue_lookup('0, 1'b0);
		queue_lookup({WORD_W{1'b1}}, 1'b0);

		run_phase(1, 30, SORTED_FILL);
		run_phase(2, 30, SORTED_FILL);
		run_phase(3, 30, SORTED_FILL);
		run_phase(16, 40, SORTED_FILL);
		calm = 1'b1;
		run_phase(100, 60, SORTED_FILL);
		settle();
		calm = 1'b0;
		run_edge_phase(TABLE_DEPTH, 40, 1'b1);
		// Counts above the depth search the whole table.
		run_edge_phase(2047, 40, 1'b0);
		run_phase(41, 40, SHUFFLED_FILL);
		run_phase(0, 20, KEEP_TABLE);

		settle();
		repeat (20) @(posedge clk);
		$display("Covered %0d table writes and %0d lookups: %0d hits, %0d hits on class id zero,",
			n_writes, n_lookups, n_hits, n_zero_id);
		$display("%0d absent keys, %0d on an empty table; %0d result words, %0d mismatches.",
			n_absent, n_empty, results_checked, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
sv/mkbs_pkg.sv
sv/mkbs_ctrl.sv
sv/mkbs_dp.sv
sv/masked_key_binary_search.sv
sv/mkbs_checker.sv
sim/tb_masked_key_binary_search.sv
